// ===== design/swm_pkg.sv =====
// swm_pkg: shared types for the sliding window median core
// sample type, controller state encoding and controller/datapath command and status bundles
// no dependencies
`default_nettype none

package swm_pkg;

	localparam int SAMPLE_W = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEL,
		ST_INS,
		ST_OUT
	} swm_state_t;

	typedef struct packed {
		logic load_x;
		logic del;
		logic ins;
		logic load_out;
	} swm_cmd_t;

	typedef struct packed {
		logic out_free;
	} swm_status_t;

endpackage

`default_nettype wire

// ===== design/swm_ctrl.sv =====
// swm_ctrl: sequencer for one request, capture, delete oldest, insert newest, publish
// depends on swm_pkg
`default_nettype none

module swm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire swm_pkg::swm_status_t status,
	output swm_pkg::swm_cmd_t        cmd
);
	import swm_pkg::*;

	swm_state_t state_q;
	swm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_x = 1'b1;
					state_d    = ST_DEL;
				end
			end
			ST_DEL: begin
				cmd.del = 1'b1;
				state_d = ST_INS;
			end
			ST_INS: begin
				cmd.ins = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/swm_datapath.sv =====
// swm_datapath: age-ordered window, sorted row of cells and output register
// depends on swm_pkg
`default_nettype none

module swm_datapath #(
	parameter int WINDOW_LEN = 30
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire swm_pkg::swm_cmd_t    cmd,
	output swm_pkg::swm_status_t      status,
	input  wire swm_pkg::sample_t     sample,
	output swm_pkg::sample_t          median,
	output logic                      median_valid,
	input  wire logic                 median_ready
);
	import swm_pkg::*;

	localparam int MID = WINDOW_LEN / 2;

	sample_t age_q    [WINDOW_LEN];
	sample_t sorted_q [WINDOW_LEN];
	sample_t del_d    [WINDOW_LEN];
	sample_t ins_d    [WINDOW_LEN];
	sample_t x_q;
	sample_t median_q;
	logic    valid_q;
	logic    [WINDOW_LEN-1:0] lt;
	sample_t oldest;

	assign oldest = age_q[WINDOW_LEN-1];

	// remove one copy of the oldest sample, upper cells shift down
	always_comb begin
		for (int i = 0; i < WINDOW_LEN - 1; i++) begin
			del_d[i] = (sorted_q[i] >= oldest) ? sorted_q[i+1] : sorted_q[i];
		end
		del_d[WINDOW_LEN-1] = sorted_q[WINDOW_LEN-1];
	end

	// insert new sample into the lower cells, top cell is free
	always_comb begin
		for (int i = 0; i < WINDOW_LEN - 1; i++) begin
			lt[i] = sorted_q[i] < x_q;
		end
		lt[WINDOW_LEN-1] = 1'b0;
		ins_d[0] = lt[0] ? sorted_q[0] : x_q;
		for (int i = 1; i < WINDOW_LEN; i++) begin
			if (lt[i]) begin
				ins_d[i] = sorted_q[i];
			end else if (lt[i-1]) begin
				ins_d[i] = x_q;
			end else begin
				ins_d[i] = sorted_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				age_q[i]    <= '0;
				sorted_q[i] <= '0;
			end
		end else begin
			if (cmd.del) begin
				for (int i = 0; i < WINDOW_LEN; i++) begin
					sorted_q[i] <= del_d[i];
				end
			end else if (cmd.ins) begin
				for (int i = 0; i < WINDOW_LEN; i++) begin
					sorted_q[i] <= ins_d[i];
				end
				age_q[0] <= x_q;
				for (int i = 1; i < WINDOW_LEN; i++) begin
					age_q[i] <= age_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= sample;
		end
		if (cmd.load_out) begin
			median_q <= sorted_q[MID];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			valid_q <= 1'b1;
		end else if (median_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign status.out_free = !valid_q || median_ready;
	assign median          = median_q;
	assign median_valid    = valid_q;

endmodule

`default_nettype wire

// ===== design/sliding_window_median_core.sv =====
// sliding_window_median_core: running median over the last WINDOW_LEN samples
// depends on swm_pkg, swm_ctrl, swm_datapath
//
// input stream s_*: one signed 16-bit sample per request
// output stream m_*: one signed 16-bit median per request, the element at
// sorted rank WINDOW_LEN/2 of the window that includes the new sample
// the window is held twice, once in arrival order to find the oldest sample
// and once as a sorted row of cells; each request deletes the oldest from the
// sorted row and inserts the new sample in the next cycle
// result: the delete, insert and publish steps follow the request in order, and the
// result is registered once the output is free; a new request is taken only back in
// idle, after the capture, delete, insert and publish steps of the controller
// reset: window is all zeros, so early medians count those zeros; no result pending
// a stalled receiver holds the result in the output register; one more request
// is still taken and waits after its insert step until the register frees
`default_nettype none

module sliding_window_median_core #(
	parameter int WINDOW_LEN = 30
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] sample
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // [15:0] median
);
	import swm_pkg::*;

	swm_cmd_t    cmd;
	swm_status_t status;
	sample_t     median;

	swm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	swm_datapath #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample_t'(s_tdata)),
		.median       (median),
		.median_valid (m_tvalid),
		.median_ready (m_tready)
	);

	assign m_tdata = 16'(median);

endmodule

`default_nettype wire

// ===== design/swm_checker.sv =====
// swm_checker: port-level checks for sliding_window_median_core, bound to the top
// depends on sliding_window_median_core ports only
`default_nettype none

module swm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [15:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	logic s_req;
	assign s_req = s_tvalid && s_tready;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("median changed or dropped while stalled");

	// no new request during delete and insert steps
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_req |=> !s_tready ##1 !s_tready)
		else $error("input taken while a request is in progress");

	// a fresh result follows its request after the delete, insert and publish steps
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_req, 4))
		else $error("result appeared without a matching request");

	// waiting input request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input request changed or dropped while waiting");

endmodule

bind sliding_window_median_core swm_checker u_swm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_sliding_window_median_core.sv =====
// tb_sliding_window_median_core: self-checking bench for the running median core
// depends on swm_pkg and sliding_window_median_core; predicts each median from a
// local copy of the sample window and checks every output request in order
`default_nettype none

module tb_sliding_window_median_core;
	import swm_pkg::*;

	localparam int WINDOW_LEN = 30;
	localparam int MEDIAN_RANK = WINDOW_LEN / 2;
	localparam int HOLD_OFF_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] sample
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] median

	sample_t pending_samples[$];
	sample_t expected_medians[$];
	sample_t window_copy[WINDOW_LEN];
	int unsigned next_slot = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit rx_hold = 1'b0;
	int errors = 0;
	int samples_sent = 0;
	int medians_checked = 0;

	sliding_window_median_core #(.WINDOW_LEN(WINDOW_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// write the sample over the oldest entry, then pick the element at the median rank
	function automatic sample_t insert_and_select_median(sample_t s);
		int less;
		int equal;
		window_copy[next_slot] = s;
		next_slot = (next_slot + 1 == WINDOW_LEN) ? 0 : next_slot + 1;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			less = 0;
			equal = 0;
			for (int j = 0; j < WINDOW_LEN; j++) begin
				if (window_copy[j] < window_copy[i])
					less++;
				else if (window_copy[j] == window_copy[i])
					equal++;
			end
			if (less <= MEDIAN_RANK && MEDIAN_RANK < less + equal)
				return window_copy[i];
		end
		return '0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_medians.push_back(insert_and_select_median(sample_t'(s_tdata)));
				samples_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_samples.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_hold) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		sample_t exp_median;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_medians.size() == 0) begin
				$error("median: unexpected request, got %0d", $signed(m_tdata));
				errors++;
			end else begin
				exp_median = expected_medians.pop_front();
				if (m_tdata !== exp_median) begin
					$error("median: expected %0d, got %0d", exp_median, $signed(m_tdata));
					errors++;
				end
				medians_checked++;
			end
		end
	end

	function automatic sample_t random_sample(int mode, sample_t base);
		case (mode)
			0: return sample_t'($urandom());
			1: return sample_t'($urandom_range(16) - 8);
			2: return $urandom_range(1) ? sample_t'(16'sh7fff - $urandom_range(3))
				: sample_t'(16'sh8000 + $urandom_range(3));
			default: return sample_t'(base + $urandom_range(200) - 100);
		endcase
	endfunction

	// bursts of one flavor: uniform, heavy ties, near extremes, noise around a random baseline
	task automatic queue_random_samples(int count);
		int mode;
		int burst;
		sample_t base;
		while (count > 0) begin
			mode = $urandom_range(3);
			burst = $urandom_range(60, 1);
			base = sample_t'($urandom());
			for (int k = 0; k < burst && count > 0; k++) begin
				pending_samples.push_back(random_sample(mode, base));
				count--;
			end
		end
	endtask

	task automatic wait_all_medians();
		while (pending_samples.size() != 0 || s_tvalid || expected_medians.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		queue_random_samples(count);
		wait_all_medians();
	endtask

	initial begin
		for (int i = 0; i < WINDOW_LEN; i++)
			window_copy[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// warm-up against the reset zeros, extremes, bit patterns and runs of ties
		pending_samples.push_back(16'sh7fff);
		pending_samples.push_back(16'sh8000);
		pending_samples.push_back(16'sh7fff);
		pending_samples.push_back(-16'sd1);
		pending_samples.push_back(16'sd1);
		pending_samples.push_back(16'sh5555);
		pending_samples.push_back(16'shaaaa);
		for (int k = 0; k < 6; k++)
			pending_samples.push_back(16'sd7);
		for (int k = 0; k < 5; k++)
			pending_samples.push_back(16'sh8000);
		for (int k = 0; k < 5; k++)
			pending_samples.push_back(16'sh7fff);
		pending_samples.push_back(16'sd0);
		pending_samples.push_back(-16'sd100);
		wait_all_medians();

		run_phase(0, 0, 400);
		run_phase(77, 0, 350);
		run_phase(0, 77, 350);
		run_phase(32, 32, 400);

		// receiver holds off while the sender keeps offering, so the input backs up
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random_samples(150);
		fork
			begin
				@(negedge clk) rx_hold = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				@(negedge clk) rx_hold = 1'b0;
			end
		join_none
		wait_all_medians();

		run_phase(32, 32, 150);

		repeat (20) @(posedge clk);
		if (expected_medians.size() != 0) begin
			$error("median: %0d expected requests never arrived", expected_medians.size());
			errors++;
		end
		$display("run covered %0d samples and %0d checked medians", samples_sent,
			medians_checked);
		$display("phases: warm-up, free flow, sender gaps, receiver stalls, mixed, hold-off");
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sliding_window_median_core.f =====
design/swm_pkg.sv
design/swm_ctrl.sv
design/swm_datapath.sv
design/sliding_window_median_core.sv
design/swm_checker.sv
tb/sv/tb_sliding_window_median_core.sv
